@@ hw/rtl/blrx_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blrx_pkg
// Types, codes and helper functions shared by the link receive engine.
// ----------------------------------------------------------------------------
package blrx_pkg;

  localparam logic [7:0] HDR_MIN     = 8'h80;
  localparam logic [7:0] LED_MIN     = 8'h20;
  localparam logic [7:0] STS_MIN     = 8'h10;
  localparam int         MAX_PAYLOAD = 60;
  localparam logic [7:0] FRAME_OVERHEAD = 8'd4;

  typedef enum logic [1:0] {
    CMD_BYTE   = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_TOGGLE = 2'd2,
    CMD_IDLE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_USB_EVENT   = 3'd0,
    KIND_PROTO_EVENT = 3'd1,
    KIND_QUEUE_ACK   = 3'd2,
    KIND_QUEUE_CLEAR = 3'd3,
    KIND_HEADER      = 3'd4,
    KIND_PAYLOAD     = 3'd5,
    KIND_CSUM_ERR    = 3'd6,
    KIND_LEN_ERR     = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    EVT_NO_HOST     = 3'd0,
    EVT_WORKING     = 3'd1,
    EVT_NOT_WORKING = 3'd2,
    EVT_REMOTE_WAKE = 3'd3,
    EVT_NOT_CONN    = 3'd4
  } evt_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_STARTED = 2'd1,
    PH_WORKING = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PEND,
    ST_HDR_RD,
    ST_HDR_OUT,
    ST_PAY_RD,
    ST_PAY_OUT
  } fsm_state_t;

  typedef struct packed {
    kind_t       kind;
    evt_t        code;
    logic        proto;
    logic        ack;
    logic [7:0]  cmd;
    logic [5:0]  len;
    logic [7:0]  data;
    logic [4:0]  led;
    logic        working;
    logic        last;
  } res_t;

  function automatic logic is_work(phase_t ph, logic host, logic wake, logic off);
    return (ph == PH_WORKING) && (host || wake) && !off;
  endfunction

  function automatic evt_t host_code(logic host, logic off);
    evt_t c;
    if (!host) begin
      c = EVT_NO_HOST;
    end else if (off) begin
      c = EVT_NOT_WORKING;
    end else begin
      c = EVT_WORKING;
    end
    return c;
  endfunction

  function automatic res_t mk_res(kind_t kind, evt_t code, logic proto, logic ack,
                                  logic [4:0] led, logic working);
    res_t r;
    r = '0;
    r.kind    = kind;
    r.code    = code;
    r.proto   = proto;
    r.ack     = ack;
    r.led     = led;
    r.working = working;
    return r;
  endfunction

endpackage

@@ hw/rtl/blrx_ifs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blrx_ifs
// Valid/ready channel interfaces of the link receive engine.
// ----------------------------------------------------------------------------
interface blrx_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] rx_byte;
  logic       line_present;

  modport source (output valid, command, rx_byte, line_present, input ready);
  modport sink   (input valid, command, rx_byte, line_present, output ready);
endinterface

interface blrx_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [2:0] event_code;
  logic       protocol_mode;
  logic       ack_success;
  logic [7:0] frame_cmd;
  logic [5:0] payload_len;
  logic [7:0] payload_byte;
  logic [4:0] led_value;
  logic       link_working;
  logic       last;

  modport source (output valid, kind, event_code, protocol_mode, ack_success, frame_cmd,
                  payload_len, payload_byte, led_value, link_working, last,
                  input ready);
  modport sink   (input valid, kind, event_code, protocol_mode, ack_success, frame_cmd,
                  payload_len, payload_byte, led_value, link_working, last,
                  output ready);
endinterface

interface blrx_cfg_if;
  logic valid;
  logic ready;
  logic fallback_protocol;

  modport source (output valid, fallback_protocol, input ready);
  modport sink   (input valid, fallback_protocol, output ready);
endinterface

@@ hw/rtl/bridge_link_rx_engine_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bridge_link_rx_engine_core
// Receive engine of a serial link to a USB bridge: frames, LED and status.
// ----------------------------------------------------------------------------
// An item is taken only in the idle state; its link results pass through the
// pending list and the output register, one per cycle while the output is not
// stalled. A good frame's header and payload bytes are read from the store in a
// read state, then sent in an output state; the input waits until the last one.
// Reset is synchronous: link state clears, fallback_protocol becomes 1,
// and the frame store is not cleared.
module bridge_link_rx_engine_core
  import blrx_pkg::*;
#(
  parameter int BUF_DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst,
  blrx_in_if.sink   item,
  blrx_out_if.source result,
  blrx_cfg_if.sink  cfg
);

  localparam int AW = $clog2(BUF_DEPTH);

  logic          fallback;
  logic          res_valid;
  logic          res_ready;
  res_t          res;
  res_t          out_q;
  logic          out_valid;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fallback <= 1'b1;
    end else if (cfg.valid) begin
      fallback <= cfg.fallback_protocol;
    end
  end

  blrx_engine #(
    .BUF_DEPTH (BUF_DEPTH),
    .AW        (AW)
  ) u_engine (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (item.valid),
    .in_ready        (item.ready),
    .in_command      (item.command),
    .in_rx_byte      (item.rx_byte),
    .in_line_present (item.line_present),
    .fallback        (fallback),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .res             (res),
    .mem_we          (mem_we),
    .mem_waddr       (mem_waddr),
    .mem_wdata       (mem_wdata),
    .mem_raddr       (mem_raddr),
    .mem_rdata       (mem_rdata)
  );

  blrx_frame_mem #(
    .DEPTH (BUF_DEPTH),
    .AW    (AW)
  ) u_frame_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output register: a result held here while the sink is not ready stalls the engine's next step.
  assign res_ready = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign result.valid         = out_valid;
  assign result.kind          = out_q.kind;
  assign result.event_code    = out_q.code;
  assign result.protocol_mode = out_q.proto;
  assign result.ack_success   = out_q.ack;
  assign result.frame_cmd     = out_q.cmd;
  assign result.payload_len   = out_q.len;
  assign result.payload_byte  = out_q.data;
  assign result.led_value     = out_q.led;
  assign result.link_working  = out_q.working;
  assign result.last          = out_q.last;

endmodule

@@ hw/rtl/blrx_frame_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blrx_frame_mem
// Frame byte store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module blrx_frame_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/blrx_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blrx_engine
// Link state, frame assembly and result sequencing around the frame store.
// ----------------------------------------------------------------------------
module blrx_engine
  import blrx_pkg::*;
#(
  parameter int BUF_DEPTH = 64,
  parameter int AW        = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    in_command,
  input  logic [7:0]    in_rx_byte,
  input  logic          in_line_present,
  input  logic          fallback,
  output logic          res_valid,
  input  logic          res_ready,
  output res_t          res,
  output logic          mem_we,
  output logic [AW-1:0] mem_waddr,
  output logic [7:0]    mem_wdata,
  output logic [AW-1:0] mem_raddr,
  input  logic [7:0]    mem_rdata
);

  localparam logic [8:0] DEPTH_W = 9'(BUF_DEPTH);

  fsm_state_t state, state_next;

  phase_t     phase, phase_next;
  logic       host, host_next;
  logic       wake, wake_next;
  logic       rproto, rproto_next;
  logic       usb_off, usb_off_next;
  logic       seen, seen_next;
  logic [4:0] led, led_next;
  logic [7:0] byte_index, byte_index_next;
  logic [7:0] frame_total, frame_total_next;
  logic [7:0] running_sum, running_sum_next;

  res_t       pend [4];
  res_t       pend_d [4];
  logic [2:0] pend_cnt, pend_n_d;
  logic [1:0] pend_idx;
  logic       frame_go;
  logic [5:0] plen, plen_d;
  logic [5:0] pay_idx;
  logic [7:0] cmd_q;

  logic       accept;
  logic       first;
  logic [8:0] idx_inc;
  logic [7:0] plen_full;
  logic [7:0] pay_addr;
  logic       pend_last;
  logic       pay_last;

  assign accept    = in_valid && in_ready;
  assign mem_wdata = in_rx_byte;
  assign pend_last = ({1'b0, pend_idx} == pend_cnt - 3'd1);
  assign pay_last  = (pay_idx == plen - 6'd1);
  assign pay_addr  = {2'b00, pay_idx} + 8'd3;

  // Decode of one accepted item: next link state and the short result list.
  always_comb begin
    phase_next       = phase;
    host_next        = host;
    wake_next        = wake;
    rproto_next      = rproto;
    usb_off_next     = usb_off;
    seen_next        = seen;
    led_next         = led;
    byte_index_next  = byte_index;
    frame_total_next = frame_total;
    running_sum_next = running_sum;
    for (int k = 0; k < 4; k++) begin
      pend_d[k] = '0;
    end
    pend_n_d  = '0;
    frame_go  = 1'b0;
    plen_d    = plen;
    mem_we    = 1'b0;
    mem_waddr = '0;
    first     = (phase == PH_STARTED);
    idx_inc   = {1'b0, byte_index} + 9'd1;
    plen_full = (frame_total >= FRAME_OVERHEAD) ? frame_total - FRAME_OVERHEAD : 8'd0;

    if (accept) begin
      unique case (cmd_t'(in_command))
        CMD_BYTE: begin
          if (phase != PH_IDLE) begin
            if (byte_index != 8'd0) begin
              if ({1'b0, byte_index} < DEPTH_W) begin
                mem_we    = 1'b1;
                mem_waddr = byte_index[AW-1:0];
              end
              if (idx_inc < {1'b0, frame_total}) begin
                running_sum_next = running_sum + in_rx_byte;
                byte_index_next  = idx_inc[7:0];
              end else begin
                byte_index_next  = '0;
                frame_total_next = '0;
                if ({1'b0, frame_total} > DEPTH_W || plen_full > 8'(MAX_PAYLOAD)) begin
                  pend_d[0] = mk_res(KIND_LEN_ERR, EVT_NO_HOST, 1'b0, 1'b0, led,
                                     is_work(phase, host, wake, usb_off));
                  pend_n_d  = 3'd1;
                end else if (running_sum != in_rx_byte) begin
                  pend_d[0] = mk_res(KIND_CSUM_ERR, EVT_NO_HOST, 1'b0, 1'b0, led,
                                     is_work(phase, host, wake, usb_off));
                  pend_n_d  = 3'd1;
                end else begin
                  frame_go = 1'b1;
                  plen_d   = plen_full[5:0];
                end
              end
            end else if (in_rx_byte >= HDR_MIN) begin
              mem_we           = 1'b1;
              mem_waddr        = '0;
              frame_total_next = {1'b0, in_rx_byte[6:0]} + 8'd2;
              running_sum_next = in_rx_byte;
              if (in_rx_byte[6:0] != 7'd0) begin
                byte_index_next = 8'd1;
              end
            end else if (in_rx_byte >= LED_MIN) begin
              led_next = in_rx_byte[4:0];
            end else if (in_rx_byte >= STS_MIN) begin
              if (first || in_rx_byte[2] != host) begin
                host_next = in_rx_byte[2];
                pend_d[pend_n_d[1:0]] = mk_res(KIND_USB_EVENT,
                  host_code(host_next, usb_off), 1'b0, 1'b0, led,
                  is_work(phase, host_next, wake_next, usb_off));
                pend_n_d = pend_n_d + 3'd1;
              end
              if (first || in_rx_byte[1] != wake) begin
                wake_next = in_rx_byte[1];
                pend_d[pend_n_d[1:0]] = mk_res(KIND_USB_EVENT,
                  wake_next ? EVT_REMOTE_WAKE : host_code(host_next, usb_off),
                  1'b0, 1'b0, led, is_work(phase, host_next, wake_next, usb_off));
                pend_n_d = pend_n_d + 3'd1;
              end
              if (first || in_rx_byte[3] != rproto) begin
                rproto_next = in_rx_byte[3];
                pend_d[pend_n_d[1:0]] = mk_res(KIND_PROTO_EVENT, EVT_NO_HOST,
                  is_work(phase, host_next, wake_next, usb_off) ? in_rx_byte[3] : fallback,
                  1'b0, led, is_work(phase, host_next, wake_next, usb_off));
                pend_n_d = pend_n_d + 3'd1;
              end
              if (first) begin
                phase_next = PH_WORKING;
              end
              pend_d[pend_n_d[1:0]] = mk_res(KIND_QUEUE_ACK, EVT_NO_HOST, 1'b0,
                in_rx_byte[0], led, is_work(phase_next, host_next, wake_next, usb_off));
              pend_n_d  = pend_n_d + 3'd1;
              seen_next = 1'b1;
            end
          end
        end
        CMD_TICK: begin
          if (phase != PH_IDLE) begin
            if (!seen) begin
              pend_d[0] = mk_res(KIND_QUEUE_CLEAR, EVT_NO_HOST, 1'b0, 1'b0, led,
                                 is_work(phase, host, wake, usb_off));
              pend_d[1] = mk_res(KIND_USB_EVENT, EVT_NOT_CONN, 1'b0, 1'b0, led, 1'b0);
              pend_d[2] = mk_res(KIND_PROTO_EVENT, EVT_NO_HOST, fallback, 1'b0, led, 1'b0);
              pend_n_d     = 3'd3;
              phase_next   = PH_IDLE;
              usb_off_next = 1'b0;
              host_next    = 1'b0;
            end else begin
              seen_next = 1'b0;
            end
          end else if (in_line_present) begin
            phase_next = PH_STARTED;
          end
        end
        CMD_TOGGLE: begin
          if (phase == PH_WORKING && host) begin
            usb_off_next = !usb_off;
            pend_d[0] = mk_res(KIND_USB_EVENT,
              usb_off_next ? EVT_NOT_WORKING : EVT_WORKING, 1'b0, 1'b0, led,
              is_work(phase, host, wake, usb_off_next));
            pend_n_d = 3'd1;
          end
        end
        CMD_IDLE: begin
          pend_d[0] = mk_res(KIND_QUEUE_CLEAR, EVT_NO_HOST, 1'b0, 1'b0, led,
                             is_work(phase, host, wake, usb_off));
          pend_d[1] = mk_res(KIND_USB_EVENT, EVT_NOT_CONN, 1'b0, 1'b0, led, 1'b0);
          pend_d[2] = mk_res(KIND_PROTO_EVENT, EVT_NO_HOST, fallback, 1'b0, led, 1'b0);
          pend_n_d     = 3'd3;
          phase_next   = PH_IDLE;
          usb_off_next = 1'b0;
          host_next    = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (frame_go) begin
            state_next = ST_HDR_RD;
          end else if (pend_n_d != 3'd0) begin
            state_next = ST_PEND;
          end
        end
      end
      ST_PEND: begin
        if (res_ready && pend_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_HDR_RD: state_next = ST_HDR_OUT;
      ST_HDR_OUT: begin
        if (res_ready) begin
          state_next = (plen == 6'd0) ? ST_IDLE : ST_PAY_RD;
        end
      end
      ST_PAY_RD: state_next = ST_PAY_OUT;
      ST_PAY_OUT: begin
        if (res_ready) begin
          state_next = pay_last ? ST_IDLE : ST_PAY_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // The read address is held through the output states so the registered
  // store data stays put while a result waits.
  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    res       = '0;
    mem_raddr = '0;
    unique case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_PEND: begin
        res_valid = 1'b1;
        res       = pend[pend_idx];
        res.last  = pend_last;
      end
      ST_HDR_RD: mem_raddr = AW'(1);
      ST_HDR_OUT: begin
        mem_raddr   = AW'(1);
        res_valid   = 1'b1;
        res         = mk_res(KIND_HEADER, EVT_NO_HOST, 1'b0, 1'b0, led,
                             is_work(phase, host, wake, usb_off));
        res.cmd     = mem_rdata;
        res.len     = plen;
        res.last    = (plen == 6'd0);
      end
      ST_PAY_RD: mem_raddr = pay_addr[AW-1:0];
      ST_PAY_OUT: begin
        mem_raddr   = pay_addr[AW-1:0];
        res_valid   = 1'b1;
        res         = mk_res(KIND_PAYLOAD, EVT_NO_HOST, 1'b0, 1'b0, led,
                             is_work(phase, host, wake, usb_off));
        res.cmd     = cmd_q;
        res.len     = plen;
        res.data    = mem_rdata;
        res.last    = pay_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      phase       <= PH_IDLE;
      host        <= 1'b0;
      wake        <= 1'b0;
      rproto      <= 1'b0;
      usb_off     <= 1'b0;
      seen        <= 1'b0;
      led         <= '0;
      byte_index  <= '0;
      frame_total <= '0;
      running_sum <= '0;
      pend_cnt    <= '0;
      pend_idx    <= '0;
      pay_idx     <= '0;
      plen        <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        phase       <= phase_next;
        host        <= host_next;
        wake        <= wake_next;
        rproto      <= rproto_next;
        usb_off     <= usb_off_next;
        seen        <= seen_next;
        led         <= led_next;
        byte_index  <= byte_index_next;
        frame_total <= frame_total_next;
        running_sum <= running_sum_next;
        pend_cnt    <= pend_n_d;
        pend_idx    <= '0;
        plen        <= plen_d;
      end
      if (state == ST_PEND && res_ready) begin
        pend_idx <= pend_idx + 2'd1;
      end
      if (state == ST_HDR_OUT) begin
        pay_idx <= '0;
      end else if (state == ST_PAY_OUT && res_ready) begin
        pay_idx <= pay_idx + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int k = 0; k < 4; k++) begin
        pend[k] <= pend_d[k];
      end
    end
    if (state == ST_HDR_OUT && res_ready) begin
      cmd_q <= mem_rdata;
    end
  end

endmodule

@@ hw/rtl/blrx_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blrx_checker
// Port-level checks of the link receive engine, bound to the top level.
// ----------------------------------------------------------------------------
module blrx_checker
  import blrx_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_kind,
  input logic [2:0] out_code,
  input logic [7:0] out_cmd,
  input logic [5:0] out_len,
  input logic [7:0] out_data,
  input logic       out_last
);

  // Results of one item are still being produced: no new item may enter.
  a_no_accept_mid_item: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_last) |-> !in_ready)
    else $error("item taken while results of the previous item are pending");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_kind == KIND_HEADER || out_kind == KIND_PAYLOAD))
      |-> (out_len <= 6'(MAX_PAYLOAD)))
    else $error("frame payload length above the limit");

  a_link_fields_clear: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_kind == KIND_USB_EVENT || out_kind == KIND_PROTO_EVENT ||
                   out_kind == KIND_QUEUE_ACK || out_kind == KIND_QUEUE_CLEAR))
      |-> (out_cmd == 8'd0 && out_len == 6'd0 && out_data == 8'd0))
    else $error("frame fields set on a link result");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_kind) && $stable(out_code) && $stable(out_data)
       && $stable(out_last)))
    else $error("stalled result changed");

endmodule

bind bridge_link_rx_engine_core blrx_checker u_blrx_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (item.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_kind  (result.kind),
  .out_code  (result.event_code),
  .out_cmd   (result.frame_cmd),
  .out_len   (result.payload_len),
  .out_data  (result.payload_byte),
  .out_last  (result.last)
);
